// File: src/aedq_pkg.sv
// Shared types and constants for the error-bounded binary32 dequantizer.
// No dependencies.
package aedq_pkg;

    localparam int unsigned QBits     = 23;
    localparam logic [31:0] CanonNan  = 32'h7FC0_0000;

    // Input stage to compute stage
    typedef struct packed {
        logic        is_bin;
        logic [22:0] bin;
        logic [31:0] word;
        logic        last;
    } aedq_item_t;

endpackage

// File: src/abs_error_dequantizer_fp32.sv
// Error-bounded binary32 dequantizer: one word in, one out per unstalled cycle.
// Depends on aedq_pkg, aedq_scale, aedq_mul.
//
// Each transaction passes an input register and a result register, and a new word
// is taken each cycle unless the output stalls; the multiply between the registers
// sets the clock. A bin below 2^23 is zigzag-decoded and scaled by twice the
// error bound; other words pass unchanged. Write error_bound only while idle.
module abs_error_dequantizer_fp32
    import aedq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] code_word
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_bits
    output logic        m_tlast
);

    logic [31:0] eb_reg;
    logic [31:0] eb2_reg;
    logic [31:0] eb2_next;
    logic        v1_reg, v2_reg;
    aedq_item_t  it_reg;
    logic [31:0] res_reg;
    logic        last_reg;
    logic [31:0] prod;
    logic        adv2, adv1;

    aedq_scale u_scale (.eb_bits(eb_reg), .eb2_bits(eb2_next));
    aedq_mul   u_mul   (.bin(it_reg.bin), .scale_bits(eb2_reg), .prod_bits(prod));

    assign adv2     = v1_reg && (!v2_reg || m_tready);
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign m_tvalid = v2_reg;
    assign m_tdata  = res_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eb_reg  <= '0;
            eb2_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end else begin
            if (cfg_we) eb_reg <= cfg_wdata;
            eb2_reg <= eb2_next;
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= 1'b1;
            else if (m_tready) v2_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            it_reg.is_bin <= (s_tdata[31:QBits] == '0);
            it_reg.bin    <= s_tdata[QBits-1:0];
            it_reg.word   <= s_tdata;
            it_reg.last   <= s_tlast;
        end
        if (adv2) begin
            res_reg  <= it_reg.is_bin ? prod : it_reg.word;
            last_reg <= it_reg.last;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    a_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        adv2 && !it_reg.is_bin |=> m_tdata == $past(it_reg.word))
        else $error("raw word altered");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_tready)
        else $error("empty stage refused input");

endmodule

// File: src/aedq_scale.sv
// Doubles the binary32 error bound with round-to-nearest-even, subnormals kept.
// Depends on aedq_pkg.
module aedq_scale
    import aedq_pkg::*;
(
    input  logic [31:0] eb_bits,
    output logic [31:0] eb2_bits
);

    logic [7:0]  exp_f;
    logic [22:0] man_f;

    always_comb begin
        exp_f = eb_bits[30:23];
        man_f = eb_bits[22:0];
        eb2_bits = eb_bits;
        if (exp_f == 8'hFF) begin
            // NaN or infinity: keep; NaN output gets canonicalized later
            eb2_bits = eb_bits;
        end else if (exp_f == 8'd0) begin
            // subnormal doubling is a shift, may carry into the normal range
            eb2_bits = {eb_bits[31], 7'd0, man_f, 1'b0};
        end else if (exp_f == 8'hFE) begin
            eb2_bits = {eb_bits[31], 8'hFF, 23'd0};
        end else begin
            eb2_bits = {eb_bits[31], exp_f + 8'd1, man_f};
        end
    end

endmodule

// File: src/aedq_mul.sv
// Binary32 product of a zigzag-coded 23-bit integer and a binary32 scale, RNE.
// Depends on aedq_pkg.
module aedq_mul
    import aedq_pkg::*;
(
    input  logic [22:0] bin,
    input  logic [31:0] scale_bits,
    output logic [31:0] prod_bits
);

    logic        q_neg;
    logic [22:0] q_mag;     // up to 2^22
    logic        s_sign;
    logic [7:0]  s_exp;
    logic [23:0] s_sig;
    logic [46:0] p;
    logic [5:0]  lz;
    logic [46:0] pn;
    logic signed [10:0] e;  // exponent of pn msb, biased
    logic [5:0]  rsh;
    logic [47:0] pr;        // pn with a sticky shifting slot
    logic [23:0] kept;
    logic        g, st;
    logic [24:0] rnd;
    logic signed [10:0] ef;
    logic        sign;

    always_comb begin
        q_neg  = bin[0];
        q_mag  = q_neg ? ({1'b0, bin[22:1]} + 23'd1) : {1'b0, bin[22:1]};
        s_sign = scale_bits[31];
        s_exp  = scale_bits[30:23];
        s_sig  = {(s_exp != 8'd0), scale_bits[22:0]};
        sign   = q_neg ^ s_sign;
        p      = q_mag * s_sig;
        lz = 6'd0;
        for (int i = 0; i < 47; i++) begin
            if (p[i]) lz = 6'(46 - i);
        end
        pn = p << lz;
        // value = pn * 2^(Es - 150 - 46 + 46 - lz); msb weight exponent:
        e = $signed({3'd0, s_exp}) + ((s_exp == 8'd0) ? 11'sd1 : 11'sd0)
            + 11'sd23 - $signed({5'd0, lz});
        rsh = 6'd0;
        if (e < 11'sd1) begin
            rsh = (e < -11'sd25) ? 6'd26 : 6'(11'sd1 - e);
        end
        pr = {pn, 1'b0} >> rsh;
        st = |({pn, 1'b0} & ~(48'hFFFF_FFFF_FFFF << rsh));
        kept = pr[47:24];
        g    = pr[23];
        st   = st | (|pr[22:0]);
        rnd  = {1'b0, kept} + {24'd0, g & (st | kept[0])};
        ef   = (e < 11'sd1) ? 11'sd0 : e;
        if (rnd[24]) begin
            ef  = ef + 11'sd1;
            rnd = rnd >> 1;
        end else if (ef == 11'sd0 && rnd[23]) begin
            ef = 11'sd1;
        end
        if (s_exp == 8'hFF) begin
            if (scale_bits[22:0] != 23'd0 || q_mag == 23'd0) prod_bits = CanonNan;
            else prod_bits = {sign, 8'hFF, 23'd0};
        end else if (p == 47'd0) begin
            prod_bits = {sign, 31'd0};
        end else if (ef >= 11'sd255) begin
            prod_bits = {sign, 8'hFF, 23'd0};
        end else begin
            prod_bits = {sign, ef[7:0], rnd[22:0]};
        end
    end

endmodule

// File: verif/testbench.sv
// Self-checking testbench for abs_error_dequantizer_fp32: random and directed code words,
// bound rewrites between phases, and a bit-exact binary32 predictor built on real math.
// Depends on aedq_pkg and the dequantizer RTL.
`timescale 1ns / 1ps

class dequant_scoreboard;
    typedef struct {
        logic [31:0] value_bits;
        logic        last;
    } value_t;

    logic [31:0] bound_bits;
    value_t      pending[$];
    int          errors;

    function new();
        bound_bits = '0;
        errors     = 0;
    endfunction

    // Widen binary32 bits to a real; every finite binary32 value fits exactly.
    function real widen(logic [31:0] b);
        logic [63:0] scale;
        real         mag;
        int          e;
        int          mant;
        if (b[30:23] == 8'hFF) begin
            return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'b0});
        end
        e     = (b[30:23] == 8'h00) ? -149 : int'(b[30:23]) - 150;
        mant  = int'({b[30:23] != 8'h00, b[22:0]});
        scale = {1'b0, 11'(e + 1023), 52'b0};
        mag   = real'(mant) * $bitstoreal(scale);
        return b[31] ? mag * -1.0 : mag;
    endfunction

    // Round a real to binary32, nearest even, subnormals kept.
    function logic [31:0] narrow(real r);
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        logic        s;
        int          e;
        int          sh;
        d = $realtobits(r);
        s = d[63];
        if (d[62:52] == 11'h7FF) begin
            return (d[51:0] != 0) ? aedq_pkg::CanonNan : {s, 8'hFF, 23'b0};
        end
        if (d[62:52] == 11'h000) begin
            return {s, 31'b0};
        end
        e  = int'(d[62:52]) - 1023;
        m  = {11'b0, 1'b1, d[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60) begin
            return {s, 31'b0};
        end
        kept = m >> sh;
        rem  = m & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) begin
            kept = kept + 1;
        end
        if (e >= -126) begin
            if (kept[24]) begin
                kept = kept >> 1;
                e    = e + 1;
            end
            if (e > 127) begin
                return {s, 8'hFF, 23'b0};
            end
            return {s, 8'(e + 127), kept[22:0]};
        end
        // a carry into bit 23 lands on the smallest normal by itself
        return {s, 31'b0} | kept[31:0];
    endfunction

    function logic [31:0] dequantize(logic [31:0] word);
        logic [31:0] scale_bits;
        int          q;
        if (word >= (32'd1 << aedq_pkg::QBits)) begin
            return word;
        end
        q          = word[0] ? -int'(word >> 1) - 1 : int'(word >> 1);
        scale_bits = narrow(2.0 * widen(bound_bits));
        return narrow(real'(q) * widen(scale_bits));
    endfunction

    function void note(logic [31:0] word, logic last);
        value_t v;
        v.value_bits = dequantize(word);
        v.last       = last;
        pending.push_back(v);
    endfunction

    function void check(logic [31:0] value_bits, logic last);
        value_t v;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result value %h last %b", $time, value_bits, last);
            errors++;
            return;
        end
        v = pending.pop_front();
        if (v.value_bits !== value_bits) begin
            $display("%0t: value mismatch expected %h actual %h", $time, v.value_bits,
                     value_bits);
            errors++;
        end
        if (v.last !== last) begin
            $display("%0t: last mismatch expected %b actual %b", $time, v.last, last);
            errors++;
        end
    endfunction
endclass

module testbench;
    import aedq_pkg::*;

    localparam int WatchdogLimit = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] code_word
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [31:0] value_bits
    logic        m_tlast;

    dequant_scoreboard sb = new();
    int  words_in = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;

    abs_error_dequantizer_fp32 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note(s_tdata, s_tlast);
                words_in++;
            end
            if (m_tvalid && m_tready) begin
                sb.check(m_tdata, m_tlast);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WatchdogLimit) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    // Receiver: ready drops in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!no_idle && aresetn && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(logic [31:0] word, logic last);
        int target;
        int gap;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        target = words_in + 1;
        do @(negedge aclk); while (words_in < target);
    endtask

    // Hold off the sender until the pipeline has drained.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_bound(logic [31:0] bits);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= bits;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.bound_bits = bits;
    endtask

    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return 32'($urandom_range(0, (1 << QBits) - 1));
        end else if (pick < 7) begin
            return 32'($urandom_range(0, 15));
        end
        return $urandom();
    endfunction

    logic [31:0] bounds[10] = '{32'h3A83_126F, 32'h0000_0000, 32'h8000_0001, 32'h0000_0001,
                                32'h7F7F_FFFF, 32'h7F80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                                32'hBF80_0000, 32'h007F_FFFF};
    logic [31:0] edge_words[20] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                                    32'h0000_0003, 32'h007F_FFFF, 32'h007F_FFFE,
                                    32'h0080_0000, 32'hFFFF_FFFF, 32'h7FC0_0001,
                                    32'hFF80_0000, 32'h7F80_0000, 32'h8000_0000,
                                    32'h0055_5555, 32'h002A_AAAA, 32'h3F80_0000,
                                    32'h0000_FFFF, 32'hFFFF_0000, 32'h0040_0000,
                                    32'h003F_FFFF, 32'h7FFF_FFFF};

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (bounds[p]) begin
            write_bound(bounds[p]);
            foreach (edge_words[i]) begin
                send_word(edge_words[i], i[0]);
            end
            for (int i = 0; i < 200; i++) begin
                if (p == 9) begin
                    no_idle = 1'b1;
                end
                if (p == 3 && i == 100) begin
                    drain();
                end
                send_word(rand_word(), 1'($urandom_range(0, 1)));
            end
        end
        write_bound($urandom());
        for (int i = 0; i < 100; i++) begin
            send_word(rand_word(), 1'($urandom_range(0, 1)));
        end
        drain();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
